>>> hw/rtl/lrc_time_tag_parser_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the LRC time-tag parser
// Concurrent checks clocked on clk; the plain form is disabled during reset.
// ----------------------------------------------------------------------------
`ifndef LRC_TIME_TAG_PARSER_TOP_ASSERT_SVH
`define LRC_TIME_TAG_PARSER_TOP_ASSERT_SVH

// Check that holds outside reset.
`define LRC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that also holds across reset.
`define LRC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/lrc_ttp_pkg.sv
// ----------------------------------------------------------------------------
// LRC time-tag parser package
// Character codes, layout codes, time constants and the stage record.
// ----------------------------------------------------------------------------
package lrc_ttp_pkg;

  localparam int TAG_WINDOW_DEFAULT = 16;

  // Positions inspected by the classifier, from '[' to the latest ']'.
  localparam int VIEW_LEN = 18;

  localparam logic [7:0] CHAR_LBRACKET = 8'h5B;
  localparam logic [7:0] CHAR_RBRACKET = 8'h5D;
  localparam logic [7:0] CHAR_DASH     = 8'h2D;
  localparam logic [7:0] CHAR_DOT      = 8'h2E;
  localparam logic [7:0] CHAR_COLON    = 8'h3A;
  localparam logic [7:0] CHAR_ZERO     = 8'h30;
  localparam logic [7:0] CHAR_NINE     = 8'h39;

  localparam logic [28:0] HOUR_MS     = 29'd3600000;
  localparam logic [28:0] MINUTE_MS   = 29'd60000;
  localparam logic [28:0] SECOND_MS   = 29'd1000;
  localparam logic [28:0] TIME_MAX_MS = 29'd359999999;

  typedef enum logic [3:0] {
    LAYOUT_INVALID        = 4'd0,
    LAYOUT_MM_SS          = 4'd1,
    LAYOUT_MM_SS_C_MS     = 4'd2,
    LAYOUT_MM_SS_CS       = 4'd3,
    LAYOUT_MM_SS_MS       = 4'd4,
    LAYOUT_HH_MM_SS_C_MS  = 4'd5,
    LAYOUT_HH_MM_SS_MS    = 4'd6,
    LAYOUT_HH_MM_SS_CS    = 4'd7,
    LAYOUT_HH_MM_SS       = 4'd8
  } layout_t;

  typedef struct packed {
    layout_t    code;
    logic       tone;
    logic [6:0] hours;
    logic [6:0] minutes;
    logic [6:0] seconds;
    logic [9:0] frac;
  } tag_fields_t;

endpackage

>>> hw/rtl/lrc_ttp_if.sv
// ----------------------------------------------------------------------------
// LRC time-tag parser channels
// Valid/ready channels for text bytes and for parsed tag results.
// ----------------------------------------------------------------------------
interface lrc_ttp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;

  modport source (output valid, output char_byte, input ready);
  modport sink (input valid, input char_byte, output ready);
endinterface

interface lrc_ttp_tag_if;
  logic        valid;
  logic        ready;
  logic [3:0]  layout_code;
  logic        tone_flag;
  logic [28:0] time_ms;

  modport source (output valid, output layout_code, output tone_flag, output time_ms,
                  input ready);
  modport sink (input valid, input layout_code, input tone_flag, input time_ms,
                output ready);
endinterface

>>> hw/rtl/lrc_ttp_classify.sv
// ----------------------------------------------------------------------------
// LRC tag classifier
// Recognizes the time-tag layout of a closed tag and extracts its fields.
// ----------------------------------------------------------------------------
module lrc_ttp_classify #(
  parameter int TAG_WINDOW = lrc_ttp_pkg::TAG_WINDOW_DEFAULT,
  localparam int POS_W = $clog2(TAG_WINDOW + 1)
) (
  input  logic [7:0]               window [TAG_WINDOW],
  input  logic [POS_W-1:0]         pos,
  input  logic [7:0]               char_byte,
  output lrc_ttp_pkg::tag_fields_t fields
);
  import lrc_ttp_pkg::*;

  logic [7:0] pos_ext;
  logic [7:0] view [VIEW_LEN];
  logic [VIEW_LEN-1:0] dig, rb, dash, dot, colon;
  logic [3:0] dval [VIEW_LEN];
  logic [VIEW_LEN-4:0] tone_ok;
  logic fits;
  layout_t code;
  logic tone;

  function automatic logic [6:0] val2(input logic [3:0] a, input logic [3:0] b);
    return 7'({3'd0, a} * 7'd10 + {3'd0, b});
  endfunction

  function automatic logic [9:0] val3(input logic [3:0] a, input logic [3:0] b,
                                      input logic [3:0] c);
    return 10'({3'd0, val2(a, b)} * 10'd10 + {6'd0, c});
  endfunction

  assign pos_ext = 8'(pos);
  assign fits = pos < POS_W'(TAG_WINDOW);

  // The byte being processed sits at the current position; later places read as zero.
  for (genvar i = 0; i < VIEW_LEN; i++) begin : g_view
    if (i < TAG_WINDOW) begin : g_win
      assign view[i] = (8'(i) < pos_ext) ? window[i] :
                       (8'(i) == pos_ext) ? char_byte : 8'h00;
    end else begin : g_pad
      assign view[i] = 8'h00;
    end
    assign dig[i]   = (view[i] >= CHAR_ZERO) && (view[i] <= CHAR_NINE);
    assign dval[i]  = view[i][3:0];
    assign rb[i]    = view[i] == CHAR_RBRACKET;
    assign dash[i]  = view[i] == CHAR_DASH;
    assign dot[i]   = view[i] == CHAR_DOT;
    assign colon[i] = view[i] == CHAR_COLON;
  end

  for (genvar i = 0; i <= VIEW_LEN - 4; i++) begin : g_tone
    assign tone_ok[i] = dig[i] && dig[i+1] && dig[i+2] && rb[i+3];
  end

  always_comb begin
    code = LAYOUT_INVALID;
    tone = 1'b0;
    if (fits && view[0] == CHAR_LBRACKET && dig[1] && dig[2] && colon[3]
        && dig[4] && dig[5]) begin
      if (rb[6]) begin
        code = LAYOUT_MM_SS;
      end else if (dash[6]) begin
        if (tone_ok[7]) begin
          code = LAYOUT_MM_SS;
          tone = 1'b1;
        end
      end else if (dot[6]) begin
        if (dig[7] && dig[8]) begin
          if (rb[9]) begin
            code = LAYOUT_MM_SS_CS;
          end else if (dash[9]) begin
            if (tone_ok[10]) begin
              code = LAYOUT_MM_SS_CS;
              tone = 1'b1;
            end
          end else if (dig[9] && rb[10]) begin
            code = LAYOUT_MM_SS_MS;
          end
        end
      end else if (colon[6] && dig[7] && dig[8]) begin
        if (dot[9]) begin
          if (dig[10] && dig[11]) begin
            if (rb[12]) begin
              code = LAYOUT_HH_MM_SS_CS;
            end else if (dash[12]) begin
              if (tone_ok[13]) begin
                code = LAYOUT_HH_MM_SS_CS;
                tone = 1'b1;
              end
            end else if (dig[12] && rb[13]) begin
              code = LAYOUT_HH_MM_SS_MS;
            end
          end
        end else if (colon[9]) begin
          if (dig[10] && dig[11] && dig[12]) begin
            if (rb[13]) begin
              code = LAYOUT_HH_MM_SS_C_MS;
            end else if (dash[13] && tone_ok[14]) begin
              code = LAYOUT_HH_MM_SS_C_MS;
              tone = 1'b1;
            end
          end
        end else if (rb[9]) begin
          code = LAYOUT_HH_MM_SS;
        end else if (dash[9]) begin
          if (tone_ok[10]) begin
            code = LAYOUT_HH_MM_SS;
            tone = 1'b1;
          end
        end else if (dig[9]) begin
          if (rb[10]) begin
            code = LAYOUT_MM_SS_C_MS;
          end else if (dash[10] && tone_ok[11]) begin
            code = LAYOUT_MM_SS_C_MS;
            tone = 1'b1;
          end
        end
      end
    end
  end

  // An invalid tag leaves every field at zero, so its time sums to zero.
  always_comb begin
    fields = '0;
    fields.code = code;
    fields.tone = tone;
    case (code)
      LAYOUT_MM_SS, LAYOUT_MM_SS_C_MS, LAYOUT_MM_SS_CS, LAYOUT_MM_SS_MS: begin
        fields.minutes = val2(dval[1], dval[2]);
        fields.seconds = val2(dval[4], dval[5]);
        if (code == LAYOUT_MM_SS_C_MS || code == LAYOUT_MM_SS_MS) begin
          fields.frac = val3(dval[7], dval[8], dval[9]);
        end else if (code == LAYOUT_MM_SS_CS) begin
          fields.frac = val3(dval[7], dval[8], 4'd0);
        end
      end
      LAYOUT_HH_MM_SS_C_MS, LAYOUT_HH_MM_SS_MS, LAYOUT_HH_MM_SS_CS, LAYOUT_HH_MM_SS: begin
        fields.hours   = val2(dval[1], dval[2]);
        fields.minutes = val2(dval[4], dval[5]);
        fields.seconds = val2(dval[7], dval[8]);
        if (code == LAYOUT_HH_MM_SS_C_MS || code == LAYOUT_HH_MM_SS_MS) begin
          fields.frac = val3(dval[10], dval[11], dval[12]);
        end else if (code == LAYOUT_HH_MM_SS_CS) begin
          fields.frac = val3(dval[10], dval[11], 4'd0);
        end
      end
      default: begin
        fields.tone = 1'b0;
      end
    endcase
  end

endmodule

>>> hw/rtl/lrc_time_tag_parser_top.sv
// ----------------------------------------------------------------------------
// LRC time-tag parser
// Finds bracketed time tags in a text byte stream and reports their time.
// ----------------------------------------------------------------------------
// The text channel takes one byte per transfer. Bytes outside a tag are
// dropped; a '[' opens a tag and the next ']' closes it. Each closing ']'
// produces one transfer on the tags channel: layout code (0 when the tag is
// malformed or does not fit in TAG_WINDOW bytes), tone flag and the time in
// milliseconds, saturated at 359999999.
// Throughput is one byte per cycle while the tags channel does not stall.
// A closing ']' passes through the input register and the classifier stage
// register, and its time sum feeds the output register on the tags channel.
// The three registers form a stalling pipeline, so while the receiver holds
// ready low the block keeps taking bytes until all stages are full.
// Synchronous reset empties the pipeline and leaves the block outside any tag;
// the tag window itself is not cleared since only bytes of the current tag
// are ever read.
module lrc_time_tag_parser_top #(
  parameter int TAG_WINDOW = lrc_ttp_pkg::TAG_WINDOW_DEFAULT
) (
  input logic            clk,
  input logic            rst,
  lrc_ttp_char_if.sink   text,
  lrc_ttp_tag_if.source  tags
);
  import lrc_ttp_pkg::*;

  localparam int POS_W = $clog2(TAG_WINDOW + 1);
  localparam int IDX_W = $clog2(TAG_WINDOW);

  logic             s0_valid;
  logic [7:0]       s0_byte;
  logic             inside_tag;
  logic [POS_W-1:0] char_position;
  logic [7:0]       tag_window [TAG_WINDOW];
  logic             mid_valid;
  tag_fields_t      mid;
  logic             out_valid;
  layout_t          out_code;
  logic             out_tone;
  logic [28:0]      out_time;

  logic             out_en, mid_en, s0_take, fits, closes;
  tag_fields_t      fields;
  logic [28:0]      time_sum, time_sat;

  assign out_en     = !out_valid || tags.ready;
  assign mid_en     = !mid_valid || out_en;
  assign s0_take    = s0_valid && mid_en;
  assign text.ready = !s0_valid || mid_en;
  assign fits       = char_position < POS_W'(TAG_WINDOW);
  assign closes     = inside_tag && (s0_byte == CHAR_RBRACKET);

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (text.ready) begin
      s0_valid <= text.valid;
    end
    if (text.valid && text.ready) begin
      s0_byte <= text.char_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      inside_tag    <= 1'b0;
      char_position <= '0;
    end else if (s0_take) begin
      if (!inside_tag) begin
        if (s0_byte == CHAR_LBRACKET) begin
          inside_tag    <= 1'b1;
          char_position <= POS_W'(1);
        end
      end else if (s0_byte == CHAR_RBRACKET) begin
        inside_tag    <= 1'b0;
        char_position <= '0;
      end else if (fits) begin
        char_position <= char_position + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s0_take) begin
      if (!inside_tag) begin
        if (s0_byte == CHAR_LBRACKET) begin
          tag_window[0] <= s0_byte;
        end
      end else if (fits) begin
        tag_window[char_position[IDX_W-1:0]] <= s0_byte;
      end
    end
  end

  lrc_ttp_classify #(
    .TAG_WINDOW (TAG_WINDOW)
  ) u_classify (
    .window    (tag_window),
    .pos       (char_position),
    .char_byte (s0_byte),
    .fields    (fields)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (mid_en) begin
      mid_valid <= s0_valid && closes;
    end
    if (s0_take && closes) begin
      mid <= fields;
    end
  end

  always_comb begin
    time_sum = 29'(mid.hours) * HOUR_MS + 29'(mid.minutes) * MINUTE_MS
             + 29'(mid.seconds) * SECOND_MS + 29'(mid.frac);
    time_sat = (time_sum > TIME_MAX_MS) ? TIME_MAX_MS : time_sum;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_en) begin
      out_valid <= mid_valid;
    end
    if (out_en && mid_valid) begin
      out_code <= mid.code;
      out_tone <= mid.tone;
      out_time <= time_sat;
    end
  end

  assign tags.valid       = out_valid;
  assign tags.layout_code = out_code;
  assign tags.tone_flag   = out_tone;
  assign tags.time_ms     = out_time;

`include "lrc_time_tag_parser_top_assert.svh"

  `LRC_ASSERT_RST(a_reset_empty, rst |=> (!inside_tag && !s0_valid && !mid_valid && !out_valid), "Reset did not empty the parser")
  `LRC_ASSERT(a_outside_no_count, !inside_tag |-> char_position == '0, "Byte count held outside a tag")
  `LRC_ASSERT(a_close_makes_result, (s0_take && closes) |=> mid_valid, "Closing bracket produced no result")
  `LRC_ASSERT(a_invalid_zero, (tags.valid && tags.layout_code == LAYOUT_INVALID) |-> (tags.time_ms == '0 && !tags.tone_flag), "Invalid tag carries time or tone")
  `LRC_ASSERT(a_time_cap, tags.valid |-> tags.time_ms <= TIME_MAX_MS, "Tag time above saturation limit")

endmodule

>>> bench/tb_lrc_time_tag_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LRC time-tag parser
// Streams text bytes into the parser and checks every tag result against
// an in-bench tag scanner: directed tags for each layout and corner first,
// then random well-formed, corrupted and free-form tags mixed with noise.
// ----------------------------------------------------------------------------
module tb_lrc_time_tag_parser_top;
  import lrc_ttp_pkg::*;

  localparam int TAG_WINDOW     = TAG_WINDOW_DEFAULT;
  localparam int TEXT_BYTES     = 1150;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    logic [7:0] ch;
    bit         hold;
  } text_item_t;

  typedef struct packed {
    layout_t     code;
    logic        tone;
    logic [28:0] ms;
  } tag_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  lrc_ttp_char_if text_ch ();
  lrc_ttp_tag_if  tag_ch ();

  lrc_time_tag_parser_top #(.TAG_WINDOW(TAG_WINDOW)) dut (
    .clk  (clk),
    .rst  (rst),
    .text (text_ch),
    .tags (tag_ch)
  );

  always #5 clk = ~clk;

  text_item_t  pending[$];
  tag_result_t tags_due[$];

  // Scanner state that mirrors the parser.
  bit         scan_open = 1'b0;
  int         scan_len = 0;
  logic [7:0] scan_win [0:TAG_WINDOW-1];

  int  tx_gap = 0;
  int  rx_stall = 0;
  int  idle_cycles = 0;
  bit  calm = 1'b0;
  int  mismatches = 0;
  int  bytes_sent = 0;
  int  results_seen = 0;
  int  valid_tags = 0;
  int  tone_tags = 0;
  int  saturated_tags = 0;

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] win_at(int i);
    if (i < scan_len && i < TAG_WINDOW) return scan_win[i];
    return 8'h00;
  endfunction

  function automatic bit is_digit(int i);
    return win_at(i) >= CHAR_ZERO && win_at(i) <= CHAR_NINE;
  endfunction

  function automatic int unsigned digit_val(int i);
    return int'(win_at(i) - CHAR_ZERO);
  endfunction

  function automatic int unsigned two_digits(int i);
    return digit_val(i) * 10 + digit_val(i + 1);
  endfunction

  // A tone suffix is three digits right before the closing bracket.
  function automatic bit tone_tail(int p);
    return is_digit(p) && is_digit(p + 1) && is_digit(p + 2) && win_at(p + 3) == CHAR_RBRACKET;
  endfunction

  function automatic layout_t classify_tag(output logic tone);
    logic [7:0] c;
    tone = 1'b0;
    if (!(win_at(0) == CHAR_LBRACKET && is_digit(1) && is_digit(2) && win_at(3) == CHAR_COLON
          && is_digit(4) && is_digit(5)))
      return LAYOUT_INVALID;
    c = win_at(6);
    if (c == CHAR_RBRACKET) return LAYOUT_MM_SS;
    if (c == CHAR_DASH) begin
      tone = tone_tail(7);
      return tone ? LAYOUT_MM_SS : LAYOUT_INVALID;
    end
    if (c == CHAR_DOT) begin
      if (!(is_digit(7) && is_digit(8))) return LAYOUT_INVALID;
      c = win_at(9);
      if (c == CHAR_RBRACKET) return LAYOUT_MM_SS_CS;
      if (c == CHAR_DASH) begin
        tone = tone_tail(10);
        return tone ? LAYOUT_MM_SS_CS : LAYOUT_INVALID;
      end
      return (is_digit(9) && win_at(10) == CHAR_RBRACKET) ? LAYOUT_MM_SS_MS : LAYOUT_INVALID;
    end
    if (c != CHAR_COLON || !(is_digit(7) && is_digit(8))) return LAYOUT_INVALID;
    c = win_at(9);
    if (c == CHAR_DOT) begin
      if (!(is_digit(10) && is_digit(11))) return LAYOUT_INVALID;
      c = win_at(12);
      if (c == CHAR_RBRACKET) return LAYOUT_HH_MM_SS_CS;
      if (c == CHAR_DASH) begin
        tone = tone_tail(13);
        return tone ? LAYOUT_HH_MM_SS_CS : LAYOUT_INVALID;
      end
      return (is_digit(12) && win_at(13) == CHAR_RBRACKET) ? LAYOUT_HH_MM_SS_MS : LAYOUT_INVALID;
    end
    if (c == CHAR_COLON) begin
      if (!(is_digit(10) && is_digit(11) && is_digit(12))) return LAYOUT_INVALID;
      if (win_at(13) == CHAR_RBRACKET) return LAYOUT_HH_MM_SS_C_MS;
      tone = win_at(13) == CHAR_DASH && tone_tail(14);
      return tone ? LAYOUT_HH_MM_SS_C_MS : LAYOUT_INVALID;
    end
    if (c == CHAR_RBRACKET) return LAYOUT_HH_MM_SS;
    if (c == CHAR_DASH) begin
      tone = tone_tail(10);
      return tone ? LAYOUT_HH_MM_SS : LAYOUT_INVALID;
    end
    if (is_digit(9)) begin
      if (win_at(10) == CHAR_RBRACKET) return LAYOUT_MM_SS_C_MS;
      tone = win_at(10) == CHAR_DASH && tone_tail(11);
      return tone ? LAYOUT_MM_SS_C_MS : LAYOUT_INVALID;
    end
    return LAYOUT_INVALID;
  endfunction

  // Advances the scanner by one accepted byte and queues the result of a closed tag.
  task automatic advance_tag_scanner(logic [7:0] b);
    bit          fits;
    logic        tone;
    layout_t     code;
    int unsigned hh, mm, ss, frac, total;
    tag_result_t r;
    if (!scan_open) begin
      if (b == CHAR_LBRACKET) begin
        scan_open = 1'b1;
        scan_win[0] = b;
        scan_len = 1;
      end
      return;
    end
    fits = scan_len < TAG_WINDOW;
    if (fits) begin
      scan_win[scan_len] = b;
      scan_len++;
    end
    if (b != CHAR_RBRACKET) return;
    tone = 1'b0;
    code = fits ? classify_tag(tone) : LAYOUT_INVALID;
    hh = 0;
    mm = 0;
    ss = 0;
    frac = 0;
    if (code >= LAYOUT_MM_SS && code <= LAYOUT_MM_SS_MS) begin
      mm = two_digits(1);
      ss = two_digits(4);
      if (code == LAYOUT_MM_SS_C_MS || code == LAYOUT_MM_SS_MS)
        frac = two_digits(7) * 10 + digit_val(9);
      else if (code == LAYOUT_MM_SS_CS)
        frac = two_digits(7) * 10;
    end else if (code >= LAYOUT_HH_MM_SS_C_MS) begin
      hh = two_digits(1);
      mm = two_digits(4);
      ss = two_digits(7);
      if (code == LAYOUT_HH_MM_SS_C_MS || code == LAYOUT_HH_MM_SS_MS)
        frac = two_digits(10) * 10 + digit_val(12);
      else if (code == LAYOUT_HH_MM_SS_CS)
        frac = two_digits(10) * 10;
    end
    total = hh * HOUR_MS + mm * MINUTE_MS + ss * SECOND_MS + frac;
    if (total > TIME_MAX_MS) total = TIME_MAX_MS;
    r.code = code;
    r.tone = (code == LAYOUT_INVALID) ? 1'b0 : tone;
    r.ms = total[28:0];
    tags_due.push_back(r);
    scan_open = 1'b0;
    scan_len = 0;
  endtask

  task automatic note_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t: %s", $realtime, what);
  endtask

  task automatic queue_bytes(logic [7:0] t[$], bit hold);
    for (int i = 0; i < t.size(); i++) pending.push_back('{t[i], hold && i == 0});
  endtask

  task automatic add_text(string s, bit hold = 1'b0);
    logic [7:0] t[$];
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    queue_bytes(t, hold);
  endtask

  // Text driver. A held byte waits until no transfer is in flight and no result is due.
  always @(posedge clk) begin
    if (rst) begin
      text_ch.valid <= 1'b0;
      tx_gap <= 0;
    end else if (!text_ch.valid || text_ch.ready) begin
      if (tx_gap != 0) begin
        tx_gap <= tx_gap - 1;
        text_ch.valid <= 1'b0;
      end else if (pending.size() != 0
                   && !(pending[0].hold && (tags_due.size() != 0 || text_ch.valid))) begin
        text_ch.char_byte <= pending[0].ch;
        text_ch.valid <= 1'b1;
        void'(pending.pop_front());
        tx_gap <= pick_gap();
      end else begin
        text_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor: predicts on each text transfer, checks each tag transfer.
  always @(posedge clk) begin
    tag_result_t want;
    if (rst) begin
      tag_ch.ready <= 1'b0;
      rx_stall <= 0;
      scan_open = 1'b0;
      scan_len = 0;
    end else begin
      if (text_ch.valid && text_ch.ready) begin
        bytes_sent++;
        advance_tag_scanner(text_ch.char_byte);
      end
      if (tag_ch.valid && tag_ch.ready) begin
        results_seen++;
        if (tags_due.size() == 0) begin
          note_mismatch($sformatf("unexpected tag result: code %0d tone %0b time %0d",
                                  tag_ch.layout_code, tag_ch.tone_flag, tag_ch.time_ms));
        end else begin
          want = tags_due.pop_front();
          if (want.code != LAYOUT_INVALID) valid_tags++;
          if (want.tone) tone_tags++;
          if (want.ms == TIME_MAX_MS) saturated_tags++;
          if (tag_ch.layout_code !== want.code || tag_ch.tone_flag !== want.tone
              || tag_ch.time_ms !== want.ms)
            note_mismatch($sformatf(
                "tag result %0d: expected code %0d tone %0b time %0d, got code %0d tone %0b time %0d",
                results_seen, want.code, want.tone, want.ms,
                tag_ch.layout_code, tag_ch.tone_flag, tag_ch.time_ms));
        end
      end
      if (rx_stall != 0) begin
        rx_stall <= rx_stall - 1;
        tag_ch.ready <= 1'b0;
      end else begin
        tag_ch.ready <= 1'b1;
        rx_stall <= pick_gap();
      end
    end
  end

  // Watchdog on cycles without any transfer; also switches calm stretches on and off.
  always @(posedge clk) begin
    if (!rst) begin
      if ((text_ch.valid && text_ch.ready) || (tag_ch.valid && tag_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if ($urandom_range(0, 299) == 0) calm <= ~calm;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles, %0d results still due",
                 $realtime, idle_cycles, tags_due.size());
        $display("tb_lrc_time_tag_parser_top NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] t[$];
    layout_t    lay;
    bit         tone;
    bit         held_mid;
    int         kind;
    int         len;
    int         pos;
    int         r;

    text_ch.valid = 1'b0;
    text_ch.char_byte = 8'h00;
    tag_ch.ready = 1'b0;
    held_mid = 1'b0;

    // Directed tags: every layout, tone suffixes, extremes and malformed cases.
    add_text("[00:00]");
    add_text("[99:99]");
    add_text("[12:34-567]");
    add_text("[01:02:003]");
    add_text("[01:02:345-678]");
    add_text("[01:02.03]");
    add_text("[59:59.99-123]");
    add_text("[01:02.999]");
    add_text("[01:02:03:456]");
    add_text("[01:02:03:456-789]");
    add_text("[01:02:03.456]");
    add_text("[01:02:03.45]");
    add_text("[01:02:03]");
    add_text("[99:59:59-999]");
    add_text("[99:99:99.999]");
    add_text("[]");
    add_text("[ar:Some Artist]");
    add_text("[[01:02]");
    add_text("[12:34-56]");
    add_text("[12:34.5]");
    add_text("[0123456789abcdefghij]");
    t = '{CHAR_LBRACKET, 8'h30, 8'h31, CHAR_COLON, 8'h00, 8'h35, CHAR_RBRACKET};
    queue_bytes(t, 1'b0);
    t = '{CHAR_LBRACKET, 8'hFF, 8'h31, CHAR_COLON, 8'h32, 8'hB5, CHAR_RBRACKET};
    queue_bytes(t, 1'b0);
    // A closing bracket and odd bytes outside any tag give nothing.
    t = '{8'hFF, 8'h80, CHAR_RBRACKET, 8'h00, 8'h7F, 8'h41};
    queue_bytes(t, 1'b0);
    add_text("[00:00:00:000]", 1'b1);

    // Random part: mostly well-formed tags with random digits.
    while (pending.size() < TEXT_BYTES) begin
      t.delete();
      kind = $urandom_range(0, 99);
      if (kind < 80) begin
        lay = layout_t'($urandom_range(1, 8));
        tone = $urandom_range(0, 2) == 0 && lay != LAYOUT_MM_SS_MS && lay != LAYOUT_HH_MM_SS_MS;
        t.push_back(CHAR_LBRACKET);
        len = (lay >= LAYOUT_HH_MM_SS_C_MS) ? 3 : 2;
        for (int f = 0; f < len; f++) begin
          if (f != 0) t.push_back(CHAR_COLON);
          repeat (2) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        case (lay)
          LAYOUT_MM_SS_C_MS, LAYOUT_HH_MM_SS_C_MS: begin
            t.push_back(CHAR_COLON);
            repeat (3) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          end
          LAYOUT_MM_SS_MS, LAYOUT_HH_MM_SS_MS: begin
            t.push_back(CHAR_DOT);
            repeat (3) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          end
          LAYOUT_MM_SS_CS, LAYOUT_HH_MM_SS_CS: begin
            t.push_back(CHAR_DOT);
            repeat (2) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          end
          default: ;
        endcase
        if (tone) begin
          t.push_back(CHAR_DASH);
          repeat (3) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        t.push_back(CHAR_RBRACKET);
        // A share of the tags gets broken by one edit.
        if (kind >= 65) begin
          pos = $urandom_range(1, t.size() - 1);
          r = $urandom_range(0, 2);
          if (r == 0) t[pos] = 8'($urandom_range(0, 255));
          else if (r == 1) t.delete(pos);
          else t.insert(pos, CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
      end else if (kind < 90) begin
        t.push_back(CHAR_LBRACKET);
        len = $urandom_range(0, 18);
        repeat (len) begin
          r = $urandom_range(0, 99);
          if (r < 60) t.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
          else if (r < 70) t.push_back(CHAR_COLON);
          else if (r < 78) t.push_back(CHAR_DOT);
          else if (r < 85) t.push_back(CHAR_DASH);
          else t.push_back(8'($urandom_range(0, 255)));
        end
        t.push_back(CHAR_RBRACKET);
      end else begin
        len = $urandom_range(1, 8);
        repeat (len) begin
          r = $urandom_range(0, 255);
          if (r == CHAR_LBRACKET && $urandom_range(0, 3) != 0) r = 8'h20;
          t.push_back(8'(r));
        end
      end
      queue_bytes(t, !held_mid && pending.size() > 700);
      if (pending.size() > 700) held_mid = 1'b1;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || text_ch.valid || tags_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Run covered %0d text bytes and %0d tag results: %0d time tags, %0d with tone,",
             bytes_sent, results_seen, valid_tags, tone_tags);
    $display("%0d saturated times and %0d invalid or overlong tags; %0d mismatches.",
             saturated_tags, results_seen - valid_tags, mismatches);
    if (mismatches == 0 && tags_due.size() == 0) begin
      $display("tb_lrc_time_tag_parser_top OK");
    end else begin
      $display("tb_lrc_time_tag_parser_top NOT OK");
    end
    $finish;
  end

endmodule
